>>> design/nfps_pkg.sv
`timescale 1ns / 1ps

package nfps_pkg;

    localparam int DEF_BANK_COUNT      = 4;
    localparam int DEF_BLOCKS_PER_BANK = 8;
    localparam int DEF_PAGES_PER_BLOCK = 16;

    localparam int CMD_W    = 2;
    localparam int BANK_W   = 3;
    localparam int BLOCK_W  = 4;
    localparam int PAGE_W   = 5;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int PTR_W    = 5;

    // s_tdata layout, low bit first
    localparam int BANK_LSB  = 0;
    localparam int BLOCK_LSB = BANK_LSB + BANK_W;
    localparam int PAGE_LSB  = BLOCK_LSB + BLOCK_W;
    localparam int WDATA_LSB = PAGE_LSB + PAGE_W;
    localparam int WSPARE_LSB = WDATA_LSB + WORD_W;
    localparam int S_PAYLOAD_W = WSPARE_LSB + WORD_W;
    localparam int S_TDATA_W = ((S_PAYLOAD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 2 * WORD_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ    = 2'd0,
        CMD_PROGRAM = 2'd1,
        CMD_ERASE   = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_BANK   = 3'd1,
        ST_BAD_BLOCK  = 3'd2,
        ST_BAD_PAGE   = 3'd3,
        ST_WRITTEN    = 3'd4,
        ST_NOT_SEQ    = 3'd5,
        ST_EMPTY_READ = 3'd6,
        ST_FREE_ERASE = 3'd7
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_t;

endpackage

>>> design/nand_flash_page_store_unit.sv
`timescale 1ns / 1ps

// NAND flash page store: banks of blocks of pages, one data and one spare word per page.
// Input channel (s_): one command beat, s_tuser = command, s_tdata = address and words.
// Result channel (m_): exactly one beat per command, m_tuser = status,
//   m_tdata = read data and spare (zero unless a read succeeds).
// An accepted command is checked in the check stage, and its result is registered
//   into the output register. A new command is taken only once the current one
//   leaves the check stage. The accept edge reads the block pointer RAM and the page
//   RAM, and the check stage checks the command and writes both back.
// The result sits in an output register; the next command is taken while it waits.
// If m_tready stays low, a finished command holds in the check stage until the
//   output register frees up, and no further command is taken.
// Reset (aresetn low, synchronous) clears the per-block valid bits,
//   so every block starts free. No clearing pass; the block is ready right away.
//   Page contents are not cleared and are only readable once programmed.
module nand_flash_page_store_unit
    import nfps_pkg::*;
#(
    parameter int BANK_COUNT      = DEF_BANK_COUNT,
    parameter int BLOCKS_PER_BANK = DEF_BLOCKS_PER_BANK,
    parameter int PAGES_PER_BLOCK = DEF_PAGES_PER_BLOCK
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] bank_index, [6:3] block_index, [11:7] page_index,
    // [43:12] write_data, [75:44] write_spare, [79:76] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] read_data, [63:32] read_spare
    output logic [M_TDATA_W-1:0] m_tdata,
    // [2:0] status
    output logic [STATUS_W-1:0]  m_tuser
);

    localparam int TOTAL_BLOCKS = BANK_COUNT * BLOCKS_PER_BANK;
    localparam int TOTAL_PAGES  = TOTAL_BLOCKS * PAGES_PER_BLOCK;
    localparam int BLK_AW  = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
    localparam int PAGE_AW = (TOTAL_PAGES > 1) ? $clog2(TOTAL_PAGES) : 1;
    localparam int BIDX_W  = 8;
    localparam int PIDX_W  = 13;

    fsm_t state_reg, state_next;

    cmd_t                cmd_reg;
    logic [BANK_W-1:0]   bank_reg;
    logic [BLOCK_W-1:0]  blk_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [WORD_W-1:0]   wdata_reg;
    logic [WORD_W-1:0]   wspare_reg;
    logic [BLK_AW-1:0]   bidx_reg;
    logic [PAGE_AW-1:0]  pidx_reg;

    logic [TOTAL_BLOCKS-1:0] ptr_vld_reg;

    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic                 s_fire, exec_fire, out_free;
    logic [BIDX_W-1:0]    s_bidx;
    logic [PIDX_W-1:0]    s_pidx;

    logic [PTR_W-1:0]     ptr_rd, wp;
    logic                 ptr_we;
    logic [PTR_W-1:0]     ptr_wr_data;
    logic                 page_we;
    logic [M_TDATA_W-1:0] page_rd;
    status_t              status;
    logic [M_TDATA_W-1:0] result_data;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;

    // flat addresses of the incoming beat; out of range only for bad bank/block/page
    assign s_bidx = BIDX_W'(s_tdata[BLOCK_LSB-1:BANK_LSB]) * BIDX_W'(BLOCKS_PER_BANK)
                  + BIDX_W'(s_tdata[PAGE_LSB-1:BLOCK_LSB]);
    assign s_pidx = PIDX_W'(s_bidx) * PIDX_W'(PAGES_PER_BLOCK)
                  + PIDX_W'(s_tdata[WDATA_LSB-1:PAGE_LSB]);

    nfps_ram #(
        .WIDTH (PTR_W),
        .DEPTH (TOTAL_BLOCKS),
        .AW    (BLK_AW)
    ) u_ptr_ram (
        .aclk    (aclk),
        .wr_en   (ptr_we),
        .wr_addr (bidx_reg),
        .wr_data (ptr_wr_data),
        .rd_en   (s_fire),
        .rd_addr (s_bidx[BLK_AW-1:0]),
        .rd_data (ptr_rd)
    );

    nfps_ram #(
        .WIDTH (M_TDATA_W),
        .DEPTH (TOTAL_PAGES),
        .AW    (PAGE_AW)
    ) u_page_ram (
        .aclk    (aclk),
        .wr_en   (page_we),
        .wr_addr (pidx_reg),
        .wr_data ({wspare_reg, wdata_reg}),
        .rd_en   (s_fire),
        .rd_addr (s_pidx[PAGE_AW-1:0]),
        .rd_data (page_rd)
    );

    // a block never written since reset reads as pointer zero
    assign wp = ptr_vld_reg[bidx_reg] ? ptr_rd : '0;

    always_comb begin
        status      = ST_OK;
        result_data = '0;
        if (cmd_reg == CMD_NOP) begin
            status = ST_OK;
        end else if (32'(bank_reg) >= BANK_COUNT) begin
            status = ST_BAD_BANK;
        end else if (32'(blk_reg) >= BLOCKS_PER_BANK) begin
            status = ST_BAD_BLOCK;
        end else if (cmd_reg == CMD_ERASE) begin
            if (wp == '0) begin
                status = ST_FREE_ERASE;
            end
        end else if (32'(page_reg) >= PAGES_PER_BLOCK) begin
            status = ST_BAD_PAGE;
        end else if (cmd_reg == CMD_READ) begin
            if (page_reg >= wp) begin
                status = ST_EMPTY_READ;
            end else begin
                result_data = page_rd;
            end
        end else begin
            if (page_reg < wp) begin
                status = ST_WRITTEN;
            end else if (page_reg > wp) begin
                status = ST_NOT_SEQ;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready    = 1'b0;
        exec_fire   = 1'b0;
        ptr_we      = 1'b0;
        ptr_wr_data = '0;
        page_we     = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                s_tready = 1'b1;
            end
            FSM_EXEC: begin
                exec_fire = out_free;
                if (out_free && status == ST_OK) begin
                    if (cmd_reg == CMD_PROGRAM) begin
                        ptr_we      = 1'b1;
                        ptr_wr_data = wp + PTR_W'(1);
                        page_we     = 1'b1;
                    end else if (cmd_reg == CMD_ERASE) begin
                        ptr_we      = 1'b1;
                        ptr_wr_data = '0;
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            ptr_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ptr_we) begin
                ptr_vld_reg[bidx_reg] <= 1'b1;
            end
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg    <= cmd_t'(s_tuser);
            bank_reg   <= s_tdata[BLOCK_LSB-1:BANK_LSB];
            blk_reg    <= s_tdata[PAGE_LSB-1:BLOCK_LSB];
            page_reg   <= s_tdata[WDATA_LSB-1:PAGE_LSB];
            wdata_reg  <= s_tdata[WSPARE_LSB-1:WDATA_LSB];
            wspare_reg <= s_tdata[S_PAYLOAD_W-1:WSPARE_LSB];
            bidx_reg   <= s_bidx[BLK_AW-1:0];
            pidx_reg   <= s_pidx[PAGE_AW-1:0];
        end
        if (exec_fire) begin
            m_status_reg <= status;
            m_data_reg   <= result_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_data_reg;

    a_result_from_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == FSM_EXEC))
        else $error("result beat without a command in the check stage");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == FSM_EXEC)
        else $error("accepted command did not enter the check stage");

    a_page_write_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        page_we |-> (cmd_reg == CMD_PROGRAM && status == ST_OK && ptr_we))
        else $error("page write without a successful program");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_we |-> 32'(ptr_wr_data) <= PAGES_PER_BLOCK)
        else $error("block pointer past the end of the block");

endmodule

>>> design/nfps_ram.sv
`timescale 1ns / 1ps

module nfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
